FILE: design/flha_pkg.sv
// ----------------------------------------------------------------------------
// Free-list heap allocator package
// Beat types of the request and response channels, datapath operation codes
// and the status group that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package flha_pkg;

  localparam int ADDR_W = 10;
  localparam int NEED_W = 11;

  // Request beat: one allocate or free command.
  typedef struct packed {
    logic              command;
    logic [1:0]        heap_select;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  // Response beat: status and payload offset.
  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] payload_address;
  } rsp_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // Operations the controller asks of the datapath, one per cycle.
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NOP       = 4'd0;
  localparam dp_op_t OP_CLEAR     = 4'd1;
  localparam dp_op_t OP_LOAD      = 4'd2;
  localparam dp_op_t OP_READ_CUR  = 4'd3;
  localparam dp_op_t OP_A_CHECK   = 4'd4;
  localparam dp_op_t OP_A_SPLIT   = 4'd5;
  localparam dp_op_t OP_A_TAKE    = 4'd6;
  localparam dp_op_t OP_A_LINK    = 4'd7;
  localparam dp_op_t OP_F_READ    = 4'd8;
  localparam dp_op_t OP_F_MARK    = 4'd9;
  localparam dp_op_t OP_F_STEP    = 4'd10;
  localparam dp_op_t OP_F_NEXT    = 4'd11;
  localparam dp_op_t OP_F_LINK    = 4'd12;
  localparam dp_op_t OP_RES_ALLOC = 4'd13;
  localparam dp_op_t OP_RES_FREE  = 4'd14;
  localparam dp_op_t OP_RES_FAIL  = 4'd15;

  // Status flags from the datapath.
  typedef struct packed {
    logic clr_last;
    logic heap_bad;
    logic is_free_cmd;
    logic free_bad;
    logic walk_ok;
    logic fwalk_ok;
    logic stop_first;
    logic best_nil;
    logic rd_free;
    logic out_ready;
  } dp_status_t;

endpackage

FILE: design/flha_datapath.sv
// ----------------------------------------------------------------------------
// Free-list heap allocator datapath
// Block memories, free-list heads, walk registers and the response register.
// Executes one operation code from the controller per cycle.
// ----------------------------------------------------------------------------
module flha_datapath #(
  parameter int HEAP_BYTES   = 1024,
  parameter int NUM_HEAPS    = 3,
  parameter int HEADER_BYTES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  flha_pkg::req_t     req,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  flha_pkg::dp_op_t   op,
  output flha_pkg::dp_status_t status,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output flha_pkg::rsp_t     rsp
);
  import flha_pkg::*;

  localparam int GRANULES = HEAP_BYTES / 8;
  localparam int HDR_G    = HEADER_BYTES / 8;
  localparam int DEPTH    = NUM_HEAPS * GRANULES;
  localparam int GW       = $clog2(GRANULES + 1);
  localparam int AW       = $clog2(DEPTH);
  localparam int HW       = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
  localparam int SW       = $clog2(HEAP_BYTES);
  localparam int STW      = $clog2(GRANULES + 2);
  localparam int XW       = SW + 4;
  localparam logic [GW-1:0] NIL = GW'(GRANULES);
  localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);

  // Block memories, indexed by heap * GRANULES + granule.
  logic [SW-1:0] size_mem [DEPTH];
  logic          free_mem [DEPTH];
  logic [GW-1:0] next_mem [DEPTH];

  logic [GW-1:0] head [NUM_HEAPS];

  logic              cmd;
  logic [1:0]        heap_raw;
  logic [HW-1:0]     heap;
  logic [NEED_W-1:0] need;
  logic [ADDR_W-1:0] baddr;
  logic [GW-1:0]     cur, prev, best, bestprev, best_next, after;
  logic [SW-1:0]     best_size, keep_size;
  logic [STW-1:0]    steps;
  logic              fit_mode;
  logic [HW-1:0]     clr_h;
  logic [GW-1:0]     clr_g;
  logic [SW-1:0]     rd_size;
  logic              rd_free;
  logic [GW-1:0]     rd_next;

  logic [HW-1:0]     load_heap;
  logic [XW-1:0]     g_full, ng_full;
  logic [GW-1:0]     g;
  logic              hit, split;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_size_en, wr_free_en, wr_next_en;
  logic [SW-1:0]     wr_size;
  logic              wr_free;
  logic [GW-1:0]     wr_next;

  function automatic logic [AW-1:0] maddr(input logic [HW-1:0] h, input logic [GW-1:0] gr);
    maddr = AW'(XW'(h) * XW'(GRANULES) + XW'(gr));
  endfunction

  // Decode of the latched command.
  always_comb begin
    load_heap = (32'(req.heap_select) < NUM_HEAPS) ? HW'(req.heap_select) : '0;
    g_full    = XW'(baddr) - XW'(HEADER_BYTES);
    g         = GW'(g_full >> 3);
    ng_full   = XW'(best) + XW'(HDR_G) + XW'(need >> 3);
    hit       = XW'(rd_size) >= XW'(need);
    split     = (XW'(best_size) > XW'(need) + XW'(HEADER_BYTES)) &&
                (ng_full < XW'(GRANULES));
  end

  // Status back to the controller.
  always_comb begin
    status.clr_last    = (32'(clr_h) == NUM_HEAPS - 1) && (32'(clr_g) == GRANULES - 1);
    status.heap_bad    = 32'(heap_raw) >= NUM_HEAPS;
    status.is_free_cmd = cmd == CMD_FREE;
    status.free_bad    = (32'(baddr) < HEADER_BYTES) || (baddr[2:0] != 3'd0) ||
                         ((g_full >> 3) >= XW'(GRANULES));
    status.walk_ok     = (cur < NIL) && (32'(steps) <= GRANULES);
    status.fwalk_ok    = (cur < NIL) && (32'(steps) <= GRANULES) && (cur < g);
    status.stop_first  = hit && (fit_mode == FIT_FIRST);
    status.best_nil    = best == NIL;
    status.rd_free     = rd_free;
    status.out_ready   = !rsp_valid || !rsp_stall;
  end

  // Memory write port selection.
  always_comb begin
    wr_addr    = maddr(heap, g);
    wr_size_en = 1'b0;
    wr_free_en = 1'b0;
    wr_next_en = 1'b0;
    wr_size    = keep_size;
    wr_free    = 1'b0;
    wr_next    = NIL;
    case (op)
      OP_CLEAR: begin
        wr_addr    = maddr(clr_h, clr_g);
        wr_size_en = 1'b1;
        wr_free_en = 1'b1;
        wr_next_en = 1'b1;
        wr_size    = (clr_g == '0) ? INIT_SIZE : '0;
        wr_free    = clr_g == '0;
      end
      OP_A_SPLIT: begin
        wr_addr    = maddr(heap, GW'(ng_full));
        wr_size_en = split;
        wr_free_en = split;
        wr_next_en = split;
        wr_size    = SW'(XW'(best_size) - XW'(need) - XW'(HEADER_BYTES));
        wr_free    = 1'b1;
        wr_next    = best_next;
      end
      OP_A_TAKE: begin
        wr_addr    = maddr(heap, best);
        wr_size_en = 1'b1;
        wr_free_en = 1'b1;
        wr_next_en = 1'b1;
      end
      OP_A_LINK: begin
        wr_addr    = maddr(heap, bestprev);
        wr_next_en = bestprev != NIL;
        wr_next    = after;
      end
      OP_F_MARK: begin
        wr_free_en = 1'b1;
        wr_free    = 1'b1;
      end
      OP_F_NEXT: begin
        wr_next_en = 1'b1;
        wr_next    = cur;
      end
      OP_F_LINK: begin
        wr_addr    = maddr(heap, prev);
        wr_next_en = prev != NIL;
        wr_next    = g;
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = (op == OP_F_READ) ? maddr(heap, g) : maddr(heap, cur);

  // Block memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_size_en) begin
      size_mem[wr_addr] <= wr_size;
    end
    if (wr_free_en) begin
      free_mem[wr_addr] <= wr_free;
    end
    if (wr_next_en) begin
      next_mem[wr_addr] <= wr_next;
    end
    rd_size <= size_mem[rd_addr];
    rd_free <= free_mem[rd_addr];
    rd_next <= next_mem[rd_addr];
  end

  // Control registers: clear counters, mode, list heads, response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_h     <= '0;
      clr_g     <= '0;
      fit_mode  <= FIT_FIRST;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_HEAPS; i++) begin
        head[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        fit_mode <= cfg_wdata;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (op)
        OP_CLEAR: begin
          if (32'(clr_g) == GRANULES - 1) begin
            clr_g <= '0;
            clr_h <= clr_h + 1'b1;
          end else begin
            clr_g <= clr_g + 1'b1;
          end
        end
        OP_A_LINK: begin
          if (bestprev == NIL) begin
            head[heap] <= after;
          end
        end
        OP_F_LINK: begin
          if (prev == NIL) begin
            head[heap] <= g;
          end
        end
        OP_RES_ALLOC, OP_RES_FREE, OP_RES_FAIL: begin
          rsp_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Walk and payload registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd      <= req.command;
        heap_raw <= req.heap_select;
        heap     <= load_heap;
        need     <= (NEED_W'(req.request_bytes) + NEED_W'(7)) & ~NEED_W'(7);
        baddr    <= req.block_address;
        cur      <= head[load_heap];
        prev     <= NIL;
        best     <= NIL;
        bestprev <= NIL;
        steps    <= '0;
      end
      OP_A_CHECK: begin
        if (hit && (fit_mode == FIT_FIRST || best == NIL || rd_size < best_size)) begin
          best      <= cur;
          bestprev  <= prev;
          best_size <= rd_size;
          best_next <= rd_next;
        end
        prev  <= cur;
        cur   <= rd_next;
        steps <= steps + 1'b1;
      end
      OP_A_SPLIT: begin
        if (split) begin
          after     <= GW'(ng_full);
          keep_size <= SW'(need);
        end else begin
          after     <= best_next;
          keep_size <= best_size;
        end
      end
      OP_F_STEP: begin
        prev  <= cur;
        cur   <= rd_next;
        steps <= steps + 1'b1;
      end
      OP_RES_ALLOC: begin
        rsp.status          <= ST_OK;
        rsp.payload_address <= ADDR_W'(XW'(best) * XW'(8) + XW'(HEADER_BYTES));
      end
      OP_RES_FREE: begin
        rsp.status          <= ST_OK;
        rsp.payload_address <= baddr;
      end
      OP_RES_FAIL: begin
        rsp.status          <= ST_FAIL;
        rsp.payload_address <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/flha_ctrl.sv
// ----------------------------------------------------------------------------
// Free-list heap allocator controller
// Sequences the clearing pass, the allocate and free walks and the response.
// ----------------------------------------------------------------------------
module flha_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  flha_pkg::dp_status_t status,
  output flha_pkg::dp_op_t     op
);
  import flha_pkg::*;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_A_RD    = 5'd3;
  localparam logic [4:0] S_A_CHK   = 5'd4;
  localparam logic [4:0] S_A_SPLIT = 5'd5;
  localparam logic [4:0] S_A_TAKE  = 5'd6;
  localparam logic [4:0] S_A_LINK  = 5'd7;
  localparam logic [4:0] S_F_RD    = 5'd8;
  localparam logic [4:0] S_F_CHK   = 5'd9;
  localparam logic [4:0] S_F_WALK  = 5'd10;
  localparam logic [4:0] S_F_STEP  = 5'd11;
  localparam logic [4:0] S_F_NEXT  = 5'd12;
  localparam logic [4:0] S_F_LINK  = 5'd13;
  localparam logic [4:0] S_RES_A   = 5'd14;
  localparam logic [4:0] S_RES_F   = 5'd15;
  localparam logic [4:0] S_RES_X   = 5'd16;

  logic [4:0] state, state_next;

  assign req_stall = state != S_IDLE;

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    op         = OP_NOP;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          op         = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (status.heap_bad) begin
          state_next = S_RES_X;
        end else if (!status.is_free_cmd) begin
          state_next = S_A_RD;
        end else if (status.free_bad) begin
          state_next = S_RES_X;
        end else begin
          state_next = S_F_RD;
        end
      end
      S_A_RD: begin
        if (status.walk_ok) begin
          op         = OP_READ_CUR;
          state_next = S_A_CHK;
        end else if (status.best_nil) begin
          state_next = S_RES_X;
        end else begin
          state_next = S_A_SPLIT;
        end
      end
      S_A_CHK: begin
        op         = OP_A_CHECK;
        state_next = status.stop_first ? S_A_SPLIT : S_A_RD;
      end
      S_A_SPLIT: begin
        op         = OP_A_SPLIT;
        state_next = S_A_TAKE;
      end
      S_A_TAKE: begin
        op         = OP_A_TAKE;
        state_next = S_A_LINK;
      end
      S_A_LINK: begin
        op         = OP_A_LINK;
        state_next = S_RES_A;
      end
      S_F_RD: begin
        op         = OP_F_READ;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (status.rd_free) begin
          state_next = S_RES_X;
        end else begin
          op         = OP_F_MARK;
          state_next = S_F_WALK;
        end
      end
      S_F_WALK: begin
        if (status.fwalk_ok) begin
          op         = OP_READ_CUR;
          state_next = S_F_STEP;
        end else begin
          state_next = S_F_NEXT;
        end
      end
      S_F_STEP: begin
        op         = OP_F_STEP;
        state_next = S_F_WALK;
      end
      S_F_NEXT: begin
        op         = OP_F_NEXT;
        state_next = S_F_LINK;
      end
      S_F_LINK: begin
        op         = OP_F_LINK;
        state_next = S_RES_F;
      end
      S_RES_A: begin
        if (status.out_ready) begin
          op         = OP_RES_ALLOC;
          state_next = S_IDLE;
        end
      end
      S_RES_F: begin
        if (status.out_ready) begin
          op         = OP_RES_FREE;
          state_next = S_IDLE;
        end
      end
      S_RES_X: begin
        if (status.out_ready) begin
          op         = OP_RES_FAIL;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/free_list_heap_allocator.sv
// ----------------------------------------------------------------------------
// Free-list heap allocator
// Address-ordered free lists over equal heaps, first-fit or best-fit search.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NUM_HEAPS * HEAP_BYTES / 8
// granules (384 at the defaults) and holds req_stall high until it is done.
// Each command is then handled one at a time. An allocate reads and checks
// each free block visited, then splits, takes and links the chosen block. A free
// reads and marks the block, walks the free blocks below the freed address, then
// links it in. A command for a heap out of range, a free of a malformed address,
// a double free and an allocate with no fit each return a failed response.
// The list walk is set by the block memories, which give one registered read
// per cycle. A finished response waits in an output register, so the next
// command is accepted while it is still stalled.
module free_list_heap_allocator #(
  parameter int HEAP_BYTES   = 1024,
  parameter int NUM_HEAPS    = 3,
  parameter int HEADER_BYTES = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  flha_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output flha_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);
  import flha_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // Sequencer.
  flha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .op        (op)
  );

  // Memories and walk registers.
  flha_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .NUM_HEAPS    (NUM_HEAPS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .op        (op),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: design/flha_checker.sv
// ----------------------------------------------------------------------------
// Free-list heap allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module flha_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input flha_pkg::rsp_t rsp
);
  import flha_pkg::*;

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // The clearing pass blocks requests right after reset.
  a_clear_stall: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during clearing pass");

  // Only one command is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second command taken while busy");

  // A failed command reports offset zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FAIL |-> rsp.payload_address == '0)
    else $error("failed response with nonzero offset");

  // Successful offsets lie on granules.
  a_ok_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_OK |-> rsp.payload_address[2:0] == 3'd0)
    else $error("unaligned payload offset");

endmodule

bind free_list_heap_allocator flha_checker u_flha_checker (.*);

FILE: test/tb_free_list_heap_allocator.sv
// ----------------------------------------------------------------------------
// Free-list heap allocator testbench
// Drives allocate and free commands into three heaps under first fit and best
// fit. A directed table covers the corner cases, then random traffic follows.
// Every response beat is checked against the table or a predictor of the free lists.
// ----------------------------------------------------------------------------
module tb_free_list_heap_allocator;
  import flha_pkg::*;

  localparam int HEAP_BYTES = 1024;
  localparam int NUM_HEAPS  = 3;
  localparam int HDR_BYTES  = 24;
  localparam int GRAN       = HEAP_BYTES / 8;
  localparam int HDR_G      = HDR_BYTES / 8;
  localparam int SETTLE_CYC = 300;
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASES     = 7;
  localparam int PHASE_LEN  = 148;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_we;
  logic cfg_wdata;

  // Model of the heaps, indexed by granule.
  int   blk_size [NUM_HEAPS][GRAN];
  bit   blk_free [NUM_HEAPS][GRAN];
  int   free_link[NUM_HEAPS][GRAN];
  int   list_head[NUM_HEAPS];
  logic fit_sel;
  int   live_blocks[NUM_HEAPS][$];

  rsp_t pending_rsp[$];
  int   errors;
  int   beats_in;
  int   beats_out;
  bit   hold_rsp;
  bit   no_gaps;

  typedef struct {
    logic cmd;
    int   heap;
    int   bytes;
    int   addr;
    bit   known;
    logic st;
    int   pa;
  } row_t;

  row_t rows[$];

  free_list_heap_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Return every heap to one free block spanning the whole heap.
  function automatic void heaps_reset();
    for (int h = 0; h < NUM_HEAPS; h++) begin
      for (int g = 0; g < GRAN; g++) begin
        blk_size[h][g]  = 0;
        blk_free[h][g]  = 1'b0;
        free_link[h][g] = GRAN;
      end
      blk_size[h][0] = HEAP_BYTES - HDR_BYTES;
      blk_free[h][0] = 1'b1;
      list_head[h]   = 0;
      live_blocks[h].delete();
    end
    fit_sel = FIT_FIRST;
  endfunction

  // Apply one command to the heap model and return the response it gives.
  function automatic rsp_t heaps_apply(req_t r);
    rsp_t o;
    int h, need, cur, prv, best, bprev, steps, s, after, ng, g;
    o.status = ST_FAIL;
    o.payload_address = '0;
    h = int'(r.heap_select);
    if (h >= NUM_HEAPS) return o;
    prv = GRAN;
    steps = 0;
    cur = list_head[h];
    if (r.command == CMD_ALLOC) begin
      need = (int'(r.request_bytes) + 7) & ~7;
      best = GRAN;
      bprev = GRAN;
      while (cur < GRAN && steps <= GRAN) begin
        s = blk_size[h][cur];
        if (s >= need) begin
          if (fit_sel == FIT_FIRST) begin
            best = cur;
            bprev = prv;
            break;
          end
          if (best == GRAN || s < blk_size[h][best]) begin
            best = cur;
            bprev = prv;
          end
        end
        prv = cur;
        cur = free_link[h][cur];
        steps++;
      end
      if (best == GRAN) return o;
      s = blk_size[h][best];
      after = free_link[h][best];
      if (s > need + HDR_BYTES) begin
        ng = best + HDR_G + need / 8;
        if (ng < GRAN) begin
          blk_size[h][ng]  = s - need - HDR_BYTES;
          blk_free[h][ng]  = 1'b1;
          free_link[h][ng] = after;
          blk_size[h][best] = need;
          after = ng;
        end
      end
      blk_free[h][best]  = 1'b0;
      free_link[h][best] = GRAN;
      if (bprev == GRAN) list_head[h] = after;
      else free_link[h][bprev] = after;
      o.status = ST_OK;
      o.payload_address = ADDR_W'(best * 8 + HDR_BYTES);
      live_blocks[h].push_back(best * 8 + HDR_BYTES);
      return o;
    end
    // Free: reject malformed addresses and double frees.
    if (r.block_address < HDR_BYTES || r.block_address[2:0] != 3'd0 ||
        (int'(r.block_address) - HDR_BYTES) / 8 >= GRAN) return o;
    g = (int'(r.block_address) - HDR_BYTES) / 8;
    if (blk_free[h][g]) return o;
    blk_free[h][g] = 1'b1;
    while (cur < GRAN && cur < g && steps <= GRAN) begin
      prv = cur;
      cur = free_link[h][cur];
      steps++;
    end
    free_link[h][g] = cur;
    if (prv == GRAN) list_head[h] = g;
    else free_link[h][prv] = g;
    for (int i = 0; i < live_blocks[h].size(); i++) begin
      if (live_blocks[h][i] == int'(r.block_address)) begin
        live_blocks[h].delete(i);
        break;
      end
    end
    o.status = ST_OK;
    o.payload_address = r.block_address;
    return o;
  endfunction

  // Offer one beat, wait for it to be taken, then record its expected response.
  task automatic send_beat(req_t r, bit known, rsp_t want);
    rsp_t got;
    int gap;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    beats_in++;
    got = heaps_apply(r);
    pending_rsp.push_back(known ? want : got);
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        6: gap = $urandom_range(20, 60);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      req <= req_t'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every response, then let any trailing work finish.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_fit(logic mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    fit_sel = mode;
  endtask

  // Build a random command, biased toward frees of live blocks.
  function automatic req_t pick_cmd(int h_bias);
    req_t r;
    int h, k, g, n;
    r = req_t'($urandom);
    h = $urandom_range(0, 99) < h_bias ? 0 : $urandom_range(0, NUM_HEAPS - 1);
    if ($urandom_range(0, 39) == 0) begin
      r.heap_select = 2'd3;
      return r;
    end
    r.heap_select = 2'(h);
    k = $urandom_range(0, 99);
    if (k < 45) begin
      r.command = CMD_ALLOC;
      if ($urandom_range(0, 9) == 0) r.request_bytes = ADDR_W'($urandom_range(0, 1023));
      else r.request_bytes = ADDR_W'($urandom_range(0, 120));
    end else if (k < 90 && live_blocks[h].size() != 0) begin
      r.command = CMD_FREE;
      r.block_address =
        ADDR_W'(live_blocks[h][$urandom_range(0, live_blocks[h].size() - 1)]);
    end else if (k < 95) begin
      // Double free of a block already on the list.
      r.command = CMD_FREE;
      g = list_head[h];
      n = $urandom_range(0, 5);
      while (n > 0 && g < GRAN && free_link[h][g] < GRAN) begin
        g = free_link[h][g];
        n--;
      end
      if (g < GRAN && g * 8 + HDR_BYTES < 1024) r.block_address = ADDR_W'(g * 8 + HDR_BYTES);
      else r.block_address = 10'd3;
    end else begin
      // Malformed address: unaligned or inside the first header.
      r.command = CMD_FREE;
      if ($urandom_range(0, 1) == 0)
        r.block_address = ADDR_W'($urandom_range(0, HDR_BYTES - 1));
      else
        r.block_address = {7'($urandom_range(0, 127)), 3'($urandom_range(1, 7))};
    end
    return r;
  endfunction

  // Receiver: random stall, with one long hold on request.
  initial begin
    int hold;
    rsp_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_rsp = 1'b0;
        rsp_stall <= 1'b0;
      end else if (no_gaps) begin
        rsp_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: rsp_stall <= 1'b1;
          5: begin
            hold = $urandom_range(15, 50);
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clk);
            rsp_stall <= 1'b0;
          end
          default: rsp_stall <= 1'b0;
        endcase
      end
    end
  end

  // Compare each accepted response beat with the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      beats_out++;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: status %0d addr %0d", rsp.status,
                   rsp.payload_address);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.payload_address !== want.payload_address) begin
          errors++;
          if (errors <= 10)
            $display("response mismatch: expected status %0d addr %0d, got %0d addr %0d",
                     want.status, want.payload_address, rsp.status, rsp.payload_address);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    int idle, last;
    idle = 0;
    last = 0;
    forever begin
      @(posedge clk);
      if (beats_in + beats_out != last) begin
        last = beats_in + beats_out;
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IDLE_LIMIT) begin
        $display("tb_free_list_heap_allocator: done, errors");
        $finish;
      end
    end
  end

  // Directed table; st and pa hold the response where it is plain to see.
  function automatic void add_row(logic cmd, int heap, int bytes, int addr, bit known,
                                  logic st, int pa);
    row_t x;
    x = '{cmd, heap, bytes, addr, known, st, pa};
    rows.push_back(x);
  endfunction

  initial begin
    req_t r;
    rsp_t want;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    hold_rsp = 1'b0;
    no_gaps = 1'b0;
    heaps_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_row(CMD_ALLOC, 0, 0,    0,    1, ST_OK,   24);
    add_row(CMD_ALLOC, 1, 1000, 1023, 1, ST_OK,   24);
    add_row(CMD_ALLOC, 1, 1,    0,    1, ST_FAIL, 0);
    add_row(CMD_ALLOC, 3, 8,    0,    1, ST_FAIL, 0);
    add_row(CMD_FREE,  0, 0,    0,    1, ST_FAIL, 0);
    add_row(CMD_FREE,  0, 1023, 23,   1, ST_FAIL, 0);
    add_row(CMD_FREE,  0, 0,    1023, 1, ST_FAIL, 0);
    add_row(CMD_FREE,  0, 0,    24,   1, ST_OK,   24);
    add_row(CMD_FREE,  0, 0,    24,   1, ST_FAIL, 0);
    add_row(CMD_FREE,  3, 0,    24,   1, ST_FAIL, 0);
    add_row(CMD_ALLOC, 2, 1023, 0,    1, ST_FAIL, 0);
    add_row(CMD_ALLOC, 2, 993,  0,    1, ST_OK,   24);
    add_row(CMD_FREE,  1, 0,    24,   1, ST_OK,   24);
    add_row(CMD_FREE,  2, 0,    24,   1, ST_OK,   24);
    add_row(CMD_ALLOC, 0, 7,    0,    0, ST_OK,   0);
    add_row(CMD_ALLOC, 0, 8,    0,    0, ST_OK,   0);
    add_row(CMD_ALLOC, 0, 9,    0,    0, ST_OK,   0);
    add_row(CMD_ALLOC, 0, 100,  0,    0, ST_OK,   0);
    add_row(CMD_FREE,  0, 0,    48,   0, ST_OK,   0);
    add_row(CMD_ALLOC, 0, 960,  0,    0, ST_OK,   0);
    add_row(CMD_ALLOC, 0, 0,    0,    0, ST_OK,   0);

    foreach (rows[i]) begin
      r.command = rows[i].cmd;
      r.heap_select = 2'(rows[i].heap);
      r.request_bytes = ADDR_W'(rows[i].bytes);
      r.block_address = ADDR_W'(rows[i].addr);
      want.status = rows[i].st;
      want.payload_address = ADDR_W'(rows[i].pa);
      send_beat(r, rows[i].known, want);
    end
    drain();

    // Random phases, switching the fit policy between them.
    for (int p = 0; p < PHASES; p++) begin
      write_fit(p % 2 == 0 ? FIT_BEST : FIT_FIRST);
      no_gaps = (p == 3);
      if (p == 2) hold_rsp = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = pick_cmd(p == 5 ? 70 : 0);
        send_beat(r, 1'b0, want);
      end
      no_gaps = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("tb_free_list_heap_allocator: done, clean");
    end else begin
      $display("tb_free_list_heap_allocator: done, errors");
    end
    $finish;
  end

endmodule
